>>> rtl/lgf_pkg.sv
// -----------------------------------------------------------------------------
// lgf_pkg
// Shared types and fixed widths of the linear gradient fill block.
// -----------------------------------------------------------------------------
package lgf_pkg;

    // Fixed field widths
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int NUM_CH    = 3;
    localparam int CH_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILL_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE   = 3'd5;

    // Last colour channel index (blue)
    localparam logic [CH_IDX_W-1:0] CH_LAST = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } t_state;

endpackage

>>> rtl/lgf_if.sv
// -----------------------------------------------------------------------------
// lgf_if
// Channel interfaces of the gradient fill: tick input, pixel output and
// configuration write channel.
// -----------------------------------------------------------------------------
interface lgf_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface lgf_out_if;
    import lgf_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic               fill_done;

    modport source (output valid, output pixel_x, output pixel_y, output red_out,
                    output green_out, output blue_out, output fill_done, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input red_out,
                    input green_out, input blue_out, input fill_done, output ready);
endinterface

interface lgf_cfg_if;
    import lgf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/lgf_divider.sv
// -----------------------------------------------------------------------------
// lgf_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module lgf_divider #(
    parameter int NUM_W = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NUM_W-1:0]         i_dividend,
    input  logic [lgf_pkg::DIM_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [NUM_W-1:0]         o_quotient
);
    import lgf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DIM_W-1:0] r_rem, n_rem;
    logic [DIM_W-1:0] r_div, n_div;
    logic             r_done, n_done;
    logic [DIM_W:0]   trial;

    // Shift in one dividend bit, subtract where the divisor fits
    always_comb begin
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[NUM_W-1]};
        if (i_start) begin
            n_cnt = CNT_W'(NUM_W);
            n_quo = i_dividend;
            n_rem = '0;
            n_div = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (trial >= {1'b0, r_div}) begin
                n_rem = DIM_W'(trial - {1'b0, r_div});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIM_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/linear_gradient_fill.sv
// -----------------------------------------------------------------------------
// linear_gradient_fill
// Streams the pixels of a linear RGB gradient over a width by height area.
// -----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (width, height, start/end colour, vertical and
//            mirror mode); always ready, latched at the next restart.
//   i_in   : one tick per transfer. A tick with restart set latches the
//            configuration, aborts any fill and computes the three channel
//            steps; it produces no pixel. A plain tick produces one pixel
//            while a fill is active and nothing otherwise.
//   o_out  : pixel coordinates, clamped channels, fill_done on the last one.
// Timing:
//   A restart keeps i_in.ready low while the single shared bit-serial
//   divider works through the three channels; for each it passes the
//   load state, runs FRACTION_BITS + 8 iterations and hands over the
//   quotient. A zero span skips the divide.
//   Plain ticks are taken one per cycle unless the receiver stalls; each
//   pixel is loaded into the output register in the cycle after its tick.
// Reset and stall:
//   Reset clears all but the payload registers, leaving the block idle.
//   A receiver stall holds one pixel in the output register and drops i_in.ready.
// -----------------------------------------------------------------------------
module linear_gradient_fill #(
    parameter int MAX_SPAN      = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lgf_cfg_if.sink   i_cfg,
    lgf_in_if.sink    i_in,
    lgf_out_if.source o_out
);
    import lgf_pkg::*;

    localparam int NUM_W = FRACTION_BITS + CH_W;
    localparam int ACC_W = FRACTION_BITS + CH_W + 1;

    // Configuration registers
    logic [DIM_W-1:0]   r_cfg_width, r_cfg_height;
    logic [COLOR_W-1:0] r_cfg_start, r_cfg_end;
    logic               r_cfg_vert, r_cfg_mirror;

    // Latched fill set-up
    logic [DIM_W-1:0]   r_lat_width, n_lat_width;
    logic [DIM_W-1:0]   r_lat_height, n_lat_height;
    logic               r_lat_vert, n_lat_vert;
    logic               r_lat_mirror, n_lat_mirror;
    logic [COLOR_W-1:0] r_lat_start, n_lat_start;
    logic [COLOR_W-1:0] r_lat_end, n_lat_end;

    // Walk and accumulator state
    t_state                  r_state, n_state;
    logic [CH_IDX_W-1:0]     r_ch, n_ch;
    logic                    r_active, n_active;
    logic [DIM_W-1:0]        r_outer, n_outer;
    logic [DIM_W-1:0]        r_inner, n_inner;
    logic signed [ACC_W-1:0] r_acc  [NUM_CH];
    logic signed [ACC_W-1:0] n_acc  [NUM_CH];
    logic signed [ACC_W-1:0] r_step [NUM_CH];
    logic signed [ACC_W-1:0] n_step [NUM_CH];

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [COORD_W-1:0] r_pix_x, n_pix_x;
    logic [COORD_W-1:0] r_pix_y, n_pix_y;
    logic [CH_W-1:0]    r_chan [NUM_CH];
    logic [CH_W-1:0]    n_chan [NUM_CH];
    logic               r_done, n_done;

    // Divider hookup and helpers
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_dividend, div_quotient;
    logic [DIM_W-1:0] div_divisor;
    logic [CH_W-1:0]  sel_start, sel_end, diff_mag;
    logic [CH_W:0]    diff;
    logic             diff_neg;
    logic             in_ready, in_xfer;
    logic [DIM_W-1:0] sat_width, sat_height, new_span, lines, line_len, mir_x;
    logic             last_pix;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (32'(v) > MAX_SPAN) ? DIM_W'(MAX_SPAN) : v;
    endfunction

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? '0 : a[FRACTION_BITS +: CH_W];
    endfunction

    // Write configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= '0;
            r_cfg_height <= '0;
            r_cfg_start  <= '0;
            r_cfg_end    <= '0;
            r_cfg_vert   <= 1'b0;
            r_cfg_mirror <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_FILL_WIDTH:    r_cfg_width  <= i_cfg.wdata[DIM_W-1:0];
                REG_FILL_HEIGHT:   r_cfg_height <= i_cfg.wdata[DIM_W-1:0];
                REG_START_COLOR:   r_cfg_start  <= i_cfg.wdata[COLOR_W-1:0];
                REG_END_COLOR:     r_cfg_end    <= i_cfg.wdata[COLOR_W-1:0];
                REG_VERTICAL_MODE: r_cfg_vert   <= i_cfg.wdata[0];
                REG_MIRROR_MODE:   r_cfg_mirror <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // Select the channel under division and form |end - start| << F
    always_comb begin
        case (r_ch)
            2'd0: begin
                sel_start = r_lat_start[23:16];
                sel_end   = r_lat_end[23:16];
            end
            2'd1: begin
                sel_start = r_lat_start[15:8];
                sel_end   = r_lat_end[15:8];
            end
            default: begin
                sel_start = r_lat_start[7:0];
                sel_end   = r_lat_end[7:0];
            end
        endcase
        diff         = {1'b0, sel_end} - {1'b0, sel_start};
        diff_neg     = diff[CH_W];
        diff_mag     = diff_neg ? CH_W'(-diff) : diff[CH_W-1:0];
        div_dividend = {diff_mag, FRACTION_BITS'(0)};
        div_divisor  = r_lat_vert ? r_lat_height : r_lat_width;
    end

    lgf_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Handshake
    assign in_ready    = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign i_in.ready  = in_ready;
    assign in_xfer     = i_in.valid && in_ready;

    // Fill geometry
    assign sat_width  = sat_dim(r_cfg_width);
    assign sat_height = sat_dim(r_cfg_height);
    assign new_span   = r_cfg_vert ? sat_height : sat_width;
    assign lines      = r_lat_vert ? r_lat_height : r_lat_width;
    assign line_len   = r_lat_vert ? r_lat_width : r_lat_height;
    assign mir_x      = r_lat_width - 1'b1 - r_outer;
    assign last_pix   = (r_outer + 1'b1 == lines) && (r_inner + 1'b1 == line_len);

    // Sequencer, walk and pixel formation
    always_comb begin
        n_state      = r_state;
        n_ch         = r_ch;
        n_active     = r_active;
        n_outer      = r_outer;
        n_inner      = r_inner;
        n_lat_width  = r_lat_width;
        n_lat_height = r_lat_height;
        n_lat_vert   = r_lat_vert;
        n_lat_mirror = r_lat_mirror;
        n_lat_start  = r_lat_start;
        n_lat_end    = r_lat_end;
        n_acc        = r_acc;
        n_step       = r_step;
        n_pix_x      = r_pix_x;
        n_pix_y      = r_pix_y;
        n_chan       = r_chan;
        n_done       = r_done;
        n_out_valid  = r_out_valid && !o_out.ready;
        div_start    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in.restart) begin
                    // Latch set-up, seed accumulators, start the divides
                    n_lat_width  = sat_width;
                    n_lat_height = sat_height;
                    n_lat_vert   = r_cfg_vert;
                    n_lat_mirror = r_cfg_mirror;
                    n_lat_start  = r_cfg_start;
                    n_lat_end    = r_cfg_end;
                    n_outer      = '0;
                    n_inner      = '0;
                    n_ch         = '0;
                    n_active     = (sat_width != '0) && (sat_height != '0);
                    for (int i = 0; i < NUM_CH; i++) begin
                        n_acc[i]  = ACC_W'({r_cfg_start[(NUM_CH-1-i)*CH_W +: CH_W],
                                            FRACTION_BITS'(0)});
                        n_step[i] = '0;
                    end
                    n_state = (new_span == '0) ? ST_IDLE : ST_LOAD;
                end else if (in_xfer && r_active) begin
                    // Advance accumulators at the head of each line
                    if (r_inner == '0) begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            n_acc[i] = r_acc[i] + r_step[i];
                        end
                    end
                    for (int i = 0; i < NUM_CH; i++) begin
                        n_chan[i] = clamp_ch(n_acc[i]);
                    end
                    if (r_lat_vert) begin
                        n_pix_x = r_inner[COORD_W-1:0];
                        n_pix_y = r_outer[COORD_W-1:0];
                    end else begin
                        n_pix_x = r_lat_mirror ? mir_x[COORD_W-1:0]
                                               : r_outer[COORD_W-1:0];
                        n_pix_y = r_inner[COORD_W-1:0];
                    end
                    n_done      = last_pix;
                    n_out_valid = 1'b1;
                    if (last_pix) begin
                        n_active = 1'b0;
                        n_outer  = '0;
                        n_inner  = '0;
                    end else if (r_inner + 1'b1 == line_len) begin
                        n_inner = '0;
                        n_outer = r_outer + 1'b1;
                    end else begin
                        n_inner = r_inner + 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                // Store the signed step, move to the next channel or back to idle after the last
                if (div_done) begin
                    n_step[r_ch] = diff_neg ? -ACC_W'({1'b0, div_quotient})
                                            :  ACC_W'({1'b0, div_quotient});
                    if (r_ch == CH_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ch         <= '0;
            r_active     <= 1'b0;
            r_outer      <= '0;
            r_inner      <= '0;
            r_out_valid  <= 1'b0;
            r_lat_width  <= '0;
            r_lat_height <= '0;
            r_lat_vert   <= 1'b0;
            r_lat_mirror <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_acc[i]  <= '0;
                r_step[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_ch         <= n_ch;
            r_active     <= n_active;
            r_outer      <= n_outer;
            r_inner      <= n_inner;
            r_out_valid  <= n_out_valid;
            r_lat_width  <= n_lat_width;
            r_lat_height <= n_lat_height;
            r_lat_vert   <= n_lat_vert;
            r_lat_mirror <= n_lat_mirror;
            r_acc        <= n_acc;
            r_step       <= n_step;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lat_start <= n_lat_start;
        r_lat_end   <= n_lat_end;
        r_pix_x     <= n_pix_x;
        r_pix_y     <= n_pix_y;
        r_chan      <= n_chan;
        r_done      <= n_done;
    end

    // Drive the output channel
    assign o_out.valid     = r_out_valid;
    assign o_out.pixel_x   = r_pix_x;
    assign o_out.pixel_y   = r_pix_y;
    assign o_out.red_out   = r_chan[0];
    assign o_out.green_out = r_chan[1];
    assign o_out.blue_out  = r_chan[2];
    assign o_out.fill_done = r_done;

endmodule
